>>> rtl/dda_line_rasterizer_defines.svh
// Assertion macros shared by the rasterizer checker.
// Depends on nothing; included by the checker file only.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DDA_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DDA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> rtl/dda_pkg.sv
// Shared opcodes and divider control/status types for the DDA rasterizer.
// No dependencies.
package dda_pkg;

   // request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // command from the pixel stepper to the increment divider
   typedef struct packed {
      logic start;
      logic neg_x;
      logic neg_y;
   } div_ctl_type;

   // divider status back to the stepper
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> rtl/dda_if.sv
// Valid/ready channel interfaces for rasterizer requests and pixel responses.
// No dependencies.
interface dda_req_if #(parameter int COORD_BITS = 12);
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;

   modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_rsp_if #(parameter int COORD_BITS = 12);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  last_pixel;

   modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
   modport sink (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

>>> rtl/dda_div.sv
// Bit-serial restoring divider producing both per-axis DDA increments.
// Depends on dda_pkg (div_ctl_type, div_stat_type).
module dda_div #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 26
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dda_pkg::div_ctl_type    ctl,
   input  logic [COORD_BITS-1:0]   step,
   input  logic [COORD_BITS-1:0]   mag_x,
   input  logic [COORD_BITS-1:0]   mag_y,
   output dda_pkg::div_stat_type   stat,
   output logic [FRAC_BITS+1:0]    inc_x,
   output logic [FRAC_BITS+1:0]    inc_y
);
   localparam int REM_W = COORD_BITS + 1;
   localparam int QUO_W = FRAC_BITS + 1;
   localparam int INC_W = FRAC_BITS + 2;
   localparam int CNT_W = $clog2(QUO_W + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(QUO_W);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] step_ff;
   logic [REM_W-1:0]      rem_x_ff, rem_y_ff;
   logic [QUO_W-1:0]      quo_x_ff, quo_y_ff;
   logic                  neg_x_ff, neg_y_ff;

   logic [REM_W-1:0] step_ext, dif_x, dif_y;
   logic             bit_x, bit_y, iterate, done;

   // one quotient bit per cycle for each lane, shared divisor
   always_comb begin
      step_ext = {1'b0, step_ff};
      bit_x    = rem_x_ff >= step_ext;
      bit_y    = rem_y_ff >= step_ext;
      dif_x    = bit_x ? rem_x_ff - step_ext : rem_x_ff;
      dif_y    = bit_y ? rem_y_ff - step_ext : rem_y_ff;
      iterate  = busy_ff && (cnt_ff != LAST_CNT);
      done     = busy_ff && (cnt_ff == LAST_CNT);
   end

   // sequencing
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (iterate) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // remainder and quotient shift registers
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         step_ff  <= step;
         rem_x_ff <= {1'b0, mag_x};
         rem_y_ff <= {1'b0, mag_y};
         neg_x_ff <= ctl.neg_x;
         neg_y_ff <= ctl.neg_y;
      end else if (iterate) begin
         rem_x_ff <= {dif_x[REM_W-2:0], 1'b0};
         rem_y_ff <= {dif_y[REM_W-2:0], 1'b0};
         quo_x_ff <= {quo_x_ff[QUO_W-2:0], bit_x};
         quo_y_ff <= {quo_y_ff[QUO_W-2:0], bit_y};
      end
   end

   // rising direction rounds up, falling direction negates the floor
   always_comb begin
      if (neg_x_ff) inc_x = INC_W'(0) - {1'b0, quo_x_ff};
      else          inc_x = {1'b0, quo_x_ff} + INC_W'(rem_x_ff != '0);
      if (neg_y_ff) inc_y = INC_W'(0) - {1'b0, quo_y_ff};
      else          inc_y = {1'b0, quo_y_ff} + INC_W'(rem_y_ff != '0);
      stat.busy = busy_ff;
      stat.done = done;
   end

endmodule

>>> rtl/dda_line_rasterizer.sv
// DDA line rasterizer top level: pixel stepper, accumulators, output register.
// Depends on dda_pkg, dda_if (dda_req_if, dda_rsp_if) and dda_div.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid/ready        opcode, start_x, start_y, end_x, end_y
//   rsp_ch    out   valid/ready        pixel_x, pixel_y, last_pixel
//
// A tick does one add per axis into the accumulators.
// A start shows its first pixel the next cycle; a line of nonzero length then
// holds off requests while the divider produces one quotient bit per cycle
// for both axes. A zero-length start does not run the divider.
// Reset is synchronous and leaves the block idle with no line active.
// A pending response that is not taken stalls further requests.
module dda_line_rasterizer #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 26
) (
   input logic       clock,
   input logic       reset,
   dda_req_if.sink   req_ch,
   dda_rsp_if.source rsp_ch
);
   localparam int ACC_W = COORD_BITS + FRAC_BITS;
   localparam int INC_W = FRAC_BITS + 2;

   logic                  active_ff, active_in;
   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] steps_ff, steps_in;
   logic [ACC_W-1:0]      x_acc_ff, y_acc_ff;
   logic [INC_W-1:0]      x_inc_ff, y_inc_ff;
   logic [COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic                  out_last_ff;

   logic                  req_ready, accept, do_start, do_tick, produce;
   logic [COORD_BITS-1:0] adx, ady, step, steps_dec;
   logic [ACC_W-1:0]      sum_x, sum_y;
   logic [INC_W-1:0]      div_inc_x, div_inc_y;
   dda_pkg::div_ctl_type  div_ctl;
   dda_pkg::div_stat_type div_stat;

   // handshake
   always_comb begin
      req_ready = !div_stat.busy && (!out_valid_ff || rsp_ch.ready);
      accept    = req_ch.valid && req_ready;
      do_start  = accept && (req_ch.opcode == dda_pkg::OP_START);
      do_tick   = accept && (req_ch.opcode == dda_pkg::OP_TICK) && active_ff;
      produce   = do_start || do_tick;
   end

   // line length and direction on start
   always_comb begin
      adx  = (req_ch.end_x >= req_ch.start_x) ? req_ch.end_x - req_ch.start_x
                                              : req_ch.start_x - req_ch.end_x;
      ady  = (req_ch.end_y >= req_ch.start_y) ? req_ch.end_y - req_ch.start_y
                                              : req_ch.start_y - req_ch.end_y;
      step = (adx > ady) ? adx : ady;
      div_ctl.start = do_start && (step != '0);
      div_ctl.neg_x = req_ch.end_x < req_ch.start_x;
      div_ctl.neg_y = req_ch.end_y < req_ch.start_y;
   end

   // accumulate with sign-extended increments
   always_comb begin
      sum_x     = x_acc_ff + {{(ACC_W-INC_W){x_inc_ff[INC_W-1]}}, x_inc_ff};
      sum_y     = y_acc_ff + {{(ACC_W-INC_W){y_inc_ff[INC_W-1]}}, y_inc_ff};
      steps_dec = steps_ff - 1'b1;
   end

   // control next state
   always_comb begin
      active_in    = active_ff;
      steps_in     = steps_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ch.ready) out_valid_in = 1'b0;
      if (produce) out_valid_in = 1'b1;
      if (do_start) begin
         active_in = step != '0;
         steps_in  = step;
      end else if (do_tick) begin
         active_in = steps_dec != '0;
         steps_in  = steps_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         steps_ff     <= '0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         steps_ff     <= steps_in;
      end
   end

   // accumulators and response register
   always_ff @(posedge clock) begin
      if (do_start) begin
         x_acc_ff    <= {req_ch.start_x, {FRAC_BITS{1'b0}}};
         y_acc_ff    <= {req_ch.start_y, {FRAC_BITS{1'b0}}};
         out_x_ff    <= req_ch.start_x;
         out_y_ff    <= req_ch.start_y;
         out_last_ff <= step == '0;
      end else if (do_tick) begin
         x_acc_ff    <= sum_x;
         y_acc_ff    <= sum_y;
         out_x_ff    <= sum_x[ACC_W-1 -: COORD_BITS];
         out_y_ff    <= sum_y[ACC_W-1 -: COORD_BITS];
         out_last_ff <= steps_dec == '0;
      end
      if (div_stat.done) begin
         x_inc_ff <= div_inc_x;
         y_inc_ff <= div_inc_y;
      end
   end

   dda_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .step  (step),
      .mag_x (adx),
      .mag_y (ady),
      .stat  (div_stat),
      .inc_x (div_inc_x),
      .inc_y (div_inc_y)
   );

   // port drive
   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pixel_x    = out_x_ff;
   assign rsp_ch.pixel_y    = out_y_ff;
   assign rsp_ch.last_pixel = out_last_ff;

endmodule

>>> rtl/dda_chk.sv
// Port-level checker for the DDA rasterizer, bound to the top level.
// Depends on dda_pkg and dda_line_rasterizer_defines.svh.
`include "dda_line_rasterizer_defines.svh"

module dda_chk #(
   parameter int COORD_BITS = 12
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_opcode,
   input logic [COORD_BITS-1:0] req_start_x,
   input logic [COORD_BITS-1:0] req_start_y,
   input logic [COORD_BITS-1:0] req_end_x,
   input logic [COORD_BITS-1:0] req_end_y,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] rsp_pixel_x,
   input logic [COORD_BITS-1:0] rsp_pixel_y,
   input logic                  rsp_last_pixel
);
   logic start_acc, flat, rsp_stall;

   assign start_acc = req_valid && req_ready && (req_opcode == dda_pkg::OP_START);
   assign flat      = (req_start_x == req_end_x) && (req_start_y == req_end_y);
   assign rsp_stall = rsp_valid && !rsp_ready;

   // start request shows its start pixel on the next cycle
   `DDA_ASSERT_NEXT(a_start_pixel, clock, reset, start_acc, rsp_valid && (rsp_pixel_x == $past(req_start_x)) && (rsp_pixel_y == $past(req_start_y)), "start pixel not shown")

   // first pixel is last only for a zero-length line
   `DDA_ASSERT_NEXT(a_start_last, clock, reset, start_acc, rsp_last_pixel == $past(flat), "wrong last flag on start pixel")

   // a line of nonzero length blocks requests while increments are computed
   `DDA_ASSERT_NEXT(a_div_hold, clock, reset, start_acc && !flat, !req_ready, "request taken during divide")

   // a stalled response blocks new requests
   `DDA_ASSERT_NOW(a_rsp_block, clock, reset, rsp_stall, !req_ready, "request taken over pending response")

   // a stalled response holds
   `DDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_last_pixel), "stalled response changed")

endmodule

bind dda_line_rasterizer dda_chk #(
   .COORD_BITS (COORD_BITS)
) u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_opcode     (req_ch.opcode),
   .req_start_x    (req_ch.start_x),
   .req_start_y    (req_ch.start_y),
   .req_end_x      (req_ch.end_x),
   .req_end_y      (req_ch.end_y),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_pixel_x    (rsp_ch.pixel_x),
   .rsp_pixel_y    (rsp_ch.pixel_y),
   .rsp_last_pixel (rsp_ch.last_pixel)
);
